>>> hdl/rhsl_pkg.sv
// rhsl_pkg: shared constants and types for the rgb to hsl conversion pipeline
// used by rhsl_div and rgb_to_hsl_convert_unit; no dependencies
package rhsl_pkg;

    localparam int CH_W              = 8;
    localparam int LSUM_W            = 9;
    localparam int HUE_INT_W         = 9;
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SAT_FRAC_BITS_DEF = 16;
    localparam int DEG_FULL          = 360;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [LSUM_W-1:0] lsum;
        logic              grey;
    } side_t;

endpackage

>>> hdl/rhsl_div.sv
// rhsl_div: pipelined restoring divider, one quotient bit per register stage
// depends on rhsl_pkg for the divisor width
module rhsl_div #(
    parameter int NSTEP = 18
) (
    input  logic                             clk,
    input  logic                             ce,
    input  logic [NSTEP+rhsl_pkg::CH_W-1:0]  num,
    input  logic [rhsl_pkg::CH_W-1:0]        den,
    output logic [NSTEP-1:0]                 quo
);
    import rhsl_pkg::*;

    localparam int NW = NSTEP + CH_W;

    logic [CH_W-1:0]  rem_reg [NSTEP-1];
    logic [NSTEP-1:0] low_reg [NSTEP-1];
    logic [CH_W-1:0]  den_reg [NSTEP-1];
    logic [NSTEP-1:0] quo_reg [NSTEP];

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        logic [CH_W-1:0]  rem_in;
        logic [NSTEP-1:0] low_in;
        logic [CH_W-1:0]  den_in;
        logic [NSTEP-1:0] quo_in;
        logic [CH_W:0]    shifted;
        logic             take;
        logic [NSTEP-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num[NW-1:NSTEP];
            assign low_in = num[NSTEP-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted  = {rem_in, low_in[NSTEP-1]};
        assign take     = (shifted >= {1'b0, den_in});
        assign quo_next = {quo_in[NSTEP-2:0], take};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                quo_reg[k] <= quo_next;
            end
        end

        if (k < NSTEP - 1)
        begin : g_carry
            logic [CH_W:0]    diff;
            logic [CH_W-1:0]  rem_next;
            logic [NSTEP-1:0] low_next;

            assign diff     = shifted - {1'b0, den_in};
            assign rem_next = take ? diff[CH_W-1:0] : shifted[CH_W-1:0];
            assign low_next = {low_in[NSTEP-2:0], 1'b0};

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= low_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[NSTEP-1];

endmodule

>>> hdl/rgb_to_hsl_convert_unit.sv
// rgb_to_hsl_convert_unit: rgb pixel to hue, saturation and lightness sum
// throughput one word per cycle except while stalled; depth set by the one-bit-per-stage dividers
// the whole pipeline stalls together only while a finished word waits at the output
// asynchronous active-low reset clears the valid bits; data registers are not reset
// depends on rhsl_pkg and rhsl_div
module rgb_to_hsl_convert_unit #(
    parameter int HUE_FRAC_BITS = rhsl_pkg::HUE_FRAC_BITS_DEF,
    parameter int SAT_FRAC_BITS = rhsl_pkg::SAT_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        pix_valid,
    output logic                                        pix_ready,
    input  logic [rhsl_pkg::CH_W-1:0]                   red,
    input  logic [rhsl_pkg::CH_W-1:0]                   green,
    input  logic [rhsl_pkg::CH_W-1:0]                   blue,
    output logic                                        hsl_valid,
    input  logic                                        hsl_ready,
    output logic [rhsl_pkg::HUE_INT_W+HUE_FRAC_BITS-1:0] hue,
    output logic [SAT_FRAC_BITS:0]                      saturation,
    output logic [rhsl_pkg::LSUM_W-1:0]                 lightness_sum
);
    import rhsl_pkg::*;

    localparam int HW       = HUE_INT_W + HUE_FRAC_BITS;
    localparam int SW       = SAT_FRAC_BITS + 1;
    localparam int HSTEP    = HUE_FRAC_BITS + 10;
    localparam int SSTEP    = SAT_FRAC_BITS + 2;
    localparam int NSTEP    = (HSTEP > SSTEP) ? HSTEP : SSTEP;
    localparam int NW       = NSTEP + CH_W;
    localparam int LAT      = NSTEP + 4;
    localparam int T_W      = CH_W + 3;
    localparam int T60_W    = T_W + 6;
    localparam logic [HW-1:0] FULL_TURN = HW'(DEG_FULL << HUE_FRAC_BITS);
    localparam logic [SW-1:0] SAT_ONE   = SW'(1) << SAT_FRAC_BITS;

    logic ce;
    logic vld_reg [LAT];

    // stage a: max, min, sector
    logic [CH_W-1:0] mx_reg, mx_next, mn_reg, mn_next, mn_rg;
    sector_t         sec_reg, sec_next;
    logic [CH_W:0]   dif_reg, dif_next;

    // stage b1: range, sum, denominator, hue numerator in sixths
    logic [CH_W-1:0]   delta_reg, delta_next, den_reg, den_next;
    logic [LSUM_W-1:0] lsum_reg, lsum_next;
    logic [T_W-1:0]    t_reg, t_next, dw, base;
    logic              grey_reg, grey_next;

    // stage b2: scaled hue numerator
    logic [T60_W-1:0]  t60_reg, t60_next;
    logic [CH_W-1:0]   delta2_reg, den2_reg;
    side_t             side2_reg;

    logic [NW-1:0]     hue_num, sat_num;
    logic [NSTEP-1:0]  hue_quo, sat_quo;
    side_t             side_reg [NSTEP];

    logic [NSTEP:0]    hue_sum, sat_sum;
    logic [HW-1:0]     hue_rnd, hue_next, hue_reg;
    logic [SW-1:0]     sat_next, sat_reg;
    logic [LSUM_W-1:0] lsum_out_reg;

    assign ce        = !vld_reg[LAT-1] || hsl_ready;
    assign pix_ready = ce;

    always_comb
    begin
        mn_rg   = (green < red) ? green : red;
        mn_next = (blue < mn_rg) ? blue : mn_rg;
        if (red >= green && red >= blue)
        begin
            sec_next = SEC_RED;
            mx_next  = red;
            dif_next = {1'b0, green} - {1'b0, blue};
        end
        else if (green >= blue)
        begin
            sec_next = SEC_GREEN;
            mx_next  = green;
            dif_next = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            sec_next = SEC_BLUE;
            mx_next  = blue;
            dif_next = {1'b0, red} - {1'b0, green};
        end
    end

    always_comb
    begin
        delta_next = mx_reg - mn_reg;
        lsum_next  = {1'b0, mx_reg} + {1'b0, mn_reg};
        den_next   = (lsum_next <= LSUM_W'(255)) ? lsum_next[CH_W-1:0]
                                                 : CH_W'(LSUM_W'(510) - lsum_next);
        grey_next  = (delta_next == '0);
        dw         = T_W'(delta_next);
        case (sec_reg)
            SEC_RED:   base = dif_reg[CH_W] ? (dw << 2) + (dw << 1) : '0;
            SEC_GREEN: base = dw << 1;
            SEC_BLUE:  base = dw << 2;
            default:   base = '0;
        endcase
        t_next   = base + {{(T_W-CH_W-1){dif_reg[CH_W]}}, dif_reg};
        t60_next = (T60_W'(t_reg) << 6) - (T60_W'(t_reg) << 2);
    end

    assign hue_num = NW'(t60_reg) << (HUE_FRAC_BITS + 1);
    assign sat_num = NW'(delta2_reg) << (SAT_FRAC_BITS + 1);

    rhsl_div #(.NSTEP(NSTEP)) u_hue_div (
        .clk (clk),
        .ce  (ce),
        .num (hue_num),
        .den (delta2_reg),
        .quo (hue_quo)
    );

    rhsl_div #(.NSTEP(NSTEP)) u_sat_div (
        .clk (clk),
        .ce  (ce),
        .num (sat_num),
        .den (den2_reg),
        .quo (sat_quo)
    );

    // round half up from one extra quotient bit, wrap a full turn to zero, zero hue and saturation on grey words
    always_comb
    begin
        hue_sum = (NSTEP+1)'(hue_quo) + (NSTEP+1)'(1);
        sat_sum = (NSTEP+1)'(sat_quo) + (NSTEP+1)'(1);
        hue_rnd = hue_sum[HW:1];
        if (side_reg[NSTEP-1].grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = (hue_rnd >= FULL_TURN) ? hue_rnd - FULL_TURN : hue_rnd;
            sat_next = sat_sum[SW:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld_reg[0] <= pix_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mx_reg       <= mx_next;
            mn_reg       <= mn_next;
            sec_reg      <= sec_next;
            dif_reg      <= dif_next;
            delta_reg    <= delta_next;
            den_reg      <= den_next;
            lsum_reg     <= lsum_next;
            t_reg        <= t_next;
            grey_reg     <= grey_next;
            t60_reg      <= t60_next;
            delta2_reg   <= delta_reg;
            den2_reg     <= den_reg;
            side2_reg    <= '{lsum: lsum_reg, grey: grey_reg};
            side_reg[0]  <= side2_reg;
            for (int i = 1; i < NSTEP; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            hue_reg      <= hue_next;
            sat_reg      <= sat_next;
            lsum_out_reg <= side_reg[NSTEP-1].lsum;
        end
    end

    assign hsl_valid     = vld_reg[LAT-1];
    assign hue           = hue_reg;
    assign saturation    = sat_reg;
    assign lightness_sum = lsum_out_reg;

`ifndef SYNTHESIS
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> hue < FULL_TURN)
        else $error("hue beyond a full turn");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> saturation <= SAT_ONE)
        else $error("saturation above one");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && saturation == '0 |-> hue == '0)
        else $error("hue set on a grey word");

    a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && (lightness_sum == '0 || lightness_sum == LSUM_W'(510))
            |-> saturation == '0)
        else $error("saturation set on black or white");
`endif

endmodule
